FILE: design/mcfe_pkg.sv
package mcfe_pkg;

   // widths of the quantizer datapath (fixed by the 32-bit inputs and 31-bit limits)
   localparam int BOUND_W = 35;              // signed clamp bounds
   localparam int SPAN_W  = 34;              // unsigned span and offset
   localparam int QMAX    = 16;              // quotient bits resolved, one per stage
   localparam int NUM_W   = SPAN_W + QMAX;   // numerator / remainder

   localparam int POS_BITS = 16;
   localparam int VAL_BITS = 12;

   localparam int KP_LIMIT = 500;
   localparam int KD_LIMIT = 5;

   localparam logic [2:0] KIND_ENABLE  = 3'd0;
   localparam logic [2:0] KIND_DISABLE = 3'd1;
   localparam logic [2:0] KIND_ZERO    = 3'd2;
   localparam logic [2:0] KIND_MIT     = 3'd3;
   localparam logic [2:0] KIND_POS_VEL = 3'd4;
   localparam logic [2:0] KIND_VEL     = 3'd5;

   localparam logic [7:0] FILL_BYTE    = 8'hFF;
   localparam logic [7:0] CMD_ENABLE   = 8'hFC;
   localparam logic [7:0] CMD_DISABLE  = 8'hFD;
   localparam logic [7:0] CMD_ZERO     = 8'hFE;
   localparam logic [3:0] NIBBLE_MASK  = 4'hF;

   localparam logic [9:0] ID_POS_VEL   = 10'h100;
   localparam logic [9:0] ID_VEL       = 10'h200;

   typedef enum logic [1:0] {
      REG_SLAVE_ID       = 2'd0,
      REG_POSITION_LIMIT = 2'd1,
      REG_VELOCITY_LIMIT = 2'd2,
      REG_TORQUE_LIMIT   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [2:0]         kind;
      logic signed [31:0] position;
      logic signed [31:0] velocity;
      logic signed [31:0] stiffness;
      logic signed [31:0] damping;
      logic signed [31:0] torque;
      logic [31:0]        position_float;
      logic [31:0]        velocity_float;
   } req_type;

   typedef struct packed {
      logic [9:0] can_id;
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic [7:0] byte2;
      logic [7:0] byte3;
      logic [7:0] byte4;
      logic [7:0] byte5;
      logic [7:0] byte6;
      logic [7:0] byte7;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] position_float;
      logic [31:0] velocity_float;
   } side_type;

endpackage

FILE: design/mcfe_quant_lane.sv
// Clamp, scale by (2^BITS - 1) and divide by the span: one quotient bit per stage.
module mcfe_quant_lane #(
   parameter int BITS = 12
) (
   input  logic                                clock,
   input  logic                                advance,
   input  logic signed [31:0]                  x,
   input  logic signed [mcfe_pkg::BOUND_W-1:0] lo,
   input  logic signed [mcfe_pkg::BOUND_W-1:0] hi,
   output logic [BITS-1:0]                     q
);
   import mcfe_pkg::*;

   // stage 1: clamp
   logic signed [BOUND_W-1:0] xe, sp, diff;
   logic [SPAN_W-1:0]         off_in, off_ff, span1_ff;
   logic                      zero_in, zero1_ff;

   assign xe   = BOUND_W'(x);
   assign sp   = hi - lo;
   assign diff = xe - lo;
   assign zero_in = (hi <= lo);

   always_comb begin
      if (xe < lo) begin
         off_in = '0;
      end else if (xe > hi) begin
         off_in = sp[SPAN_W-1:0];
      end else begin
         off_in = diff[SPAN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         off_ff   <= off_in;
         span1_ff <= sp[SPAN_W-1:0];
         zero1_ff <= zero_in;
      end
   end

   // stage 2 onward: numerator, then restoring division
   logic [NUM_W-1:0]  rem_ff  [QMAX+1];
   logic [QMAX-1:0]   quo_ff  [QMAX+1];
   logic [SPAN_W-1:0] span_ff [QMAX+1];
   logic              zero_ff [QMAX+1];

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff[0]  <= (NUM_W'(off_ff) << BITS) - NUM_W'(off_ff);
         quo_ff[0]  <= '0;
         span_ff[0] <= span1_ff;
         zero_ff[0] <= zero1_ff;
      end
   end

   for (genvar k = 0; k < QMAX; k++) begin : g_step
      logic [NUM_W-1:0] trial;
      logic             ge;
      assign trial = NUM_W'(span_ff[k]) << (QMAX - 1 - k);
      assign ge    = (rem_ff[k] >= trial);
      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k+1]  <= ge ? (rem_ff[k] - trial) : rem_ff[k];
            quo_ff[k+1]  <= {quo_ff[k][QMAX-2:0], ge};
            span_ff[k+1] <= span_ff[k];
            zero_ff[k+1] <= zero_ff[k];
         end
      end
   end

   // empty range encodes as zero
   assign q = zero_ff[QMAX] ? '0 : quo_ff[QMAX][BITS-1:0];

endmodule

FILE: design/motor_command_frame_encoder.sv
// Motor command frame encoder.
// req_ channel: one command beat (kind plus MIT fixed-point values and raw
// float32 words) per frame. rsp_ channel: one beat per accepted command with
// the CAN identifier and the eight payload bytes. Commands of kind 6 or 7 are
// accepted and dropped without a response beat.
// csr_ channel: register writes (slave id, position/velocity/torque limits),
// always ready; write only while no command is in flight.
// Path from request beat to the registered response: a clamp stage, a
// numerator stage, 16 restoring-division stages (one quotient bit each, five
// lanes side by side) and the output register.
// Throughput: one beat per cycle unless stalled, set by the fully pipelined lanes.
// Reset (synchronous) empties the pipeline and loads the register defaults.
// When the receiver stalls, the whole pipeline holds and req_ready drops; no
// beat is lost or repeated.
module motor_command_frame_encoder #(
   parameter int FRAC_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  mcfe_pkg::req_type         req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output mcfe_pkg::rsp_type         rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  mcfe_pkg::csr_index_type   csr_index,
   input  logic [31:0]               csr_data
);
   import mcfe_pkg::*;

   localparam int PIPE_DEPTH = QMAX + 2;
   localparam logic signed [BOUND_W-1:0] KP_HI =
      BOUND_W'(longint'(KP_LIMIT) << FRAC_BITS);
   localparam logic signed [BOUND_W-1:0] KD_HI =
      BOUND_W'(longint'(KD_LIMIT) << FRAC_BITS);

   // configuration registers
   logic [7:0]  slave_id_ff;
   logic [30:0] pos_lim_ff, vel_lim_ff, tor_lim_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_id_ff <= 8'd1;
         pos_lim_ff  <= 31'd819200;
         vel_lim_ff  <= 31'd1966080;
         tor_lim_ff  <= 31'd655360;
      end else if (csr_valid) begin
         case (csr_index)
            REG_SLAVE_ID:       slave_id_ff <= csr_data[7:0];
            REG_POSITION_LIMIT: pos_lim_ff  <= csr_data[30:0];
            REG_VELOCITY_LIMIT: vel_lim_ff  <= csr_data[30:0];
            REG_TORQUE_LIMIT:   tor_lim_ff  <= csr_data[30:0];
            default: ;
         endcase
      end
   end

   // symmetric bounds
   logic signed [BOUND_W-1:0] pos_hi, vel_hi, tor_hi;
   assign pos_hi = signed'({4'b0, pos_lim_ff});
   assign vel_hi = signed'({4'b0, vel_lim_ff});
   assign tor_hi = signed'({4'b0, tor_lim_ff});

   // global stall: everything moves when the output slot is free
   logic advance;
   logic rsp_valid_ff;
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   // quantizer lanes
   logic [POS_BITS-1:0] q_pos;
   logic [VAL_BITS-1:0] q_vel, q_kp, q_kd, q_tor;

   mcfe_quant_lane #(.BITS(POS_BITS)) u_pos (
      .clock(clock), .advance(advance), .x(req_data.position),
      .lo(-pos_hi), .hi(pos_hi), .q(q_pos));
   mcfe_quant_lane #(.BITS(VAL_BITS)) u_vel (
      .clock(clock), .advance(advance), .x(req_data.velocity),
      .lo(-vel_hi), .hi(vel_hi), .q(q_vel));
   mcfe_quant_lane #(.BITS(VAL_BITS)) u_kp (
      .clock(clock), .advance(advance), .x(req_data.stiffness),
      .lo('0), .hi(KP_HI), .q(q_kp));
   mcfe_quant_lane #(.BITS(VAL_BITS)) u_kd (
      .clock(clock), .advance(advance), .x(req_data.damping),
      .lo('0), .hi(KD_HI), .q(q_kd));
   mcfe_quant_lane #(.BITS(VAL_BITS)) u_tor (
      .clock(clock), .advance(advance), .x(req_data.torque),
      .lo(-tor_hi), .hi(tor_hi), .q(q_tor));

   // side data and valid bits, aligned with the lanes
   side_type side_ff  [PIPE_DEPTH];
   logic     valid_ff [PIPE_DEPTH];
   logic     kind_ok;

   assign kind_ok = (req_data.kind <= KIND_VEL);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PIPE_DEPTH; i++) valid_ff[i] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= req_valid && kind_ok;
         for (int i = 1; i < PIPE_DEPTH; i++) valid_ff[i] <= valid_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff[0] <= '{kind: req_data.kind,
                         position_float: req_data.position_float,
                         velocity_float: req_data.velocity_float};
         for (int i = 1; i < PIPE_DEPTH; i++) side_ff[i] <= side_ff[i-1];
      end
   end

   // frame packing
   side_type tail;
   rsp_type  rsp_in, rsp_ff;
   logic [9:0] base_id;

   assign tail    = side_ff[PIPE_DEPTH-1];
   assign base_id = {2'b00, slave_id_ff};

   always_comb begin
      rsp_in = '0;
      rsp_in.can_id = base_id;
      case (tail.kind)
         KIND_ENABLE, KIND_DISABLE, KIND_ZERO: begin
            rsp_in.byte0 = FILL_BYTE;
            rsp_in.byte1 = FILL_BYTE;
            rsp_in.byte2 = FILL_BYTE;
            rsp_in.byte3 = FILL_BYTE;
            rsp_in.byte4 = FILL_BYTE;
            rsp_in.byte5 = FILL_BYTE;
            rsp_in.byte6 = FILL_BYTE;
            rsp_in.byte7 = (tail.kind == KIND_ENABLE)  ? CMD_ENABLE :
                           (tail.kind == KIND_DISABLE) ? CMD_DISABLE : CMD_ZERO;
         end
         KIND_MIT: begin
            // big-endian nibble packing: 16/12/12/12/12
            rsp_in.byte0 = q_pos[15:8];
            rsp_in.byte1 = q_pos[7:0];
            rsp_in.byte2 = q_vel[11:4];
            rsp_in.byte3 = {q_vel[3:0] & NIBBLE_MASK, q_kp[11:8]};
            rsp_in.byte4 = q_kp[7:0];
            rsp_in.byte5 = q_kd[11:4];
            rsp_in.byte6 = {q_kd[3:0] & NIBBLE_MASK, q_tor[11:8]};
            rsp_in.byte7 = q_tor[7:0];
         end
         KIND_POS_VEL: begin
            rsp_in.can_id = base_id + ID_POS_VEL;
            rsp_in.byte0 = tail.position_float[7:0];
            rsp_in.byte1 = tail.position_float[15:8];
            rsp_in.byte2 = tail.position_float[23:16];
            rsp_in.byte3 = tail.position_float[31:24];
            rsp_in.byte4 = tail.velocity_float[7:0];
            rsp_in.byte5 = tail.velocity_float[15:8];
            rsp_in.byte6 = tail.velocity_float[23:16];
            rsp_in.byte7 = tail.velocity_float[31:24];
         end
         KIND_VEL: begin
            rsp_in.can_id = base_id + ID_VEL;
            rsp_in.byte0 = tail.velocity_float[7:0];
            rsp_in.byte1 = tail.velocity_float[15:8];
            rsp_in.byte2 = tail.velocity_float[23:16];
            rsp_in.byte3 = tail.velocity_float[31:24];
         end
         default: ;
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= valid_ff[PIPE_DEPTH-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks
   a_drop_bad_kind: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !kind_ok) |=> !valid_ff[0])
      else $error("unknown kind entered pipeline");

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("input accepted during output stall");

   a_tail_kind: assert property (@(posedge clock) disable iff (reset)
      valid_ff[PIPE_DEPTH-1] |-> (tail.kind <= KIND_VEL))
      else $error("invalid kind at pipeline tail");

   a_id_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.can_id[9:8] != 2'b11))
      else $error("can_id out of range");

endmodule
